[hdl/kmsd_pkg.sv]
// shared constants, pin tables and status types of the key matrix scanner
package kmsd_pkg;

   localparam int ROWS_DEF  = 5;
   localparam int COLS_DEF  = 8;
   localparam int SIDES_DEF = 2;

   localparam int PINS_W     = 16;
   localparam int TIME_W     = 32;
   localparam int KIND_W     = 2;
   localparam int KEY_IDX_W  = 7;
   localparam int ROW_W      = 3;
   localparam int WIRED_COLS = 8;
   localparam int PIN_IDX_W  = 4;

   localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;

   localparam logic [PINS_W-1:0] ALL_ONES    = 16'hffff;
   localparam logic [1:0]        PHASE_NONE  = 2'd0;
   localparam logic [1:0]        PHASE_A     = 2'd1;
   localparam logic [1:0]        PHASE_B     = 2'd2;
   localparam logic [1:0]        BOTH_PHASES = 2'd3;

   localparam logic [PIN_IDX_W-1:0] COL_PIN_L [WIRED_COLS] =
      '{4'd13, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4};
   localparam logic [PIN_IDX_W-1:0] COL_PIN_R [WIRED_COLS] =
      '{4'd3, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12};
   localparam logic [PIN_IDX_W-1:0] ENC_PIN_L [2] = '{4'd3, 4'd2};
   localparam logic [PIN_IDX_W-1:0] ENC_PIN_R [2] = '{4'd13, 4'd14};

   function automatic logic [PIN_IDX_W-1:0] col_pin(input logic side, input logic [2:0] col);
      logic [PIN_IDX_W-1:0] p;
      p = side ? COL_PIN_R[col] : COL_PIN_L[col];
      return p;
   endfunction

   function automatic logic [PIN_IDX_W-1:0] enc_pin(input logic side, input logic rot);
      logic [PIN_IDX_W-1:0] p;
      p = side ? ENC_PIN_R[rot] : ENC_PIN_L[rot];
      return p;
   endfunction

   typedef struct packed {
      logic advance;
      logic done_take;
   } seq_ctl_type;

   typedef struct packed {
      logic              step_valid;
      logic              sample_on;
      logic              done_pend;
      logic [ROW_W-1:0]  drive_row;
      logic [1:0]        fault;
      logic [TIME_W-1:0] time_stamp;
   } seq_sts_type;

endpackage

[hdl/kmsd_hist_ram.sv]
// key history memory, one synchronous read and one write port, valid bit per entry
module kmsd_hist_ram #(
   parameter int DEPTH  = 84,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [1:0]        rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [1:0]        wr_data
);

   logic [1:0] mem [DEPTH];
   logic       valid_ff [DEPTH];
   logic [1:0] rd_data_ff;
   logic       rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= valid_ff[rd_addr] || (wr_en && (wr_addr == rd_addr));
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : 2'b00;

endmodule

[hdl/kmsd_scan_seq.sv]
// scan sequencer: latches one row scan, walks its keys and decodes the encoders
module kmsd_scan_seq #(
   parameter int ROWS  = kmsd_pkg::ROWS_DEF,
   parameter int COLS  = kmsd_pkg::COLS_DEF,
   parameter int SIDES = kmsd_pkg::SIDES_DEF,
   parameter int KEY_W = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [1:0]                         side_enable,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [kmsd_pkg::PINS_W-1:0]        left_pins,
   input  logic [kmsd_pkg::PINS_W-1:0]        right_pins,
   input  logic [1:0]                         side_ready,
   input  logic [kmsd_pkg::TIME_W-1:0]        time_stamp,
   input  kmsd_pkg::seq_ctl_type              ctl,
   output kmsd_pkg::seq_sts_type              sts,
   output logic [KEY_W-1:0]                   step_key
);

   localparam int POS_W    = $clog2(COLS + 2);
   localparam int MAT_SIDE = ROWS * COLS;
   localparam int MAT_KEYS = SIDES * ROWS * COLS;
   localparam logic [POS_W-1:0] POS_ROT0  = POS_W'(COLS);
   localparam logic [POS_W-1:0] POS_ROT1  = POS_W'(COLS + 1);
   localparam logic             SIDE_LAST = 1'(SIDES - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                        state_ff, state_in;
   logic                              side_ff, side_in;
   logic [POS_W-1:0]                  pos_ff, pos_in;
   logic [kmsd_pkg::PINS_W-1:0]       pins_ff [2];
   logic [kmsd_pkg::PINS_W-1:0]       pins_in [2];
   logic [kmsd_pkg::ROW_W-1:0]        curr_ff, curr_in;
   logic [kmsd_pkg::ROW_W-1:0]        row_ff, row_in;
   logic [1:0]                        fault_ff, fault_in;
   logic [kmsd_pkg::TIME_W-1:0]       time_ff, time_in;
   logic [1:0]                        phase_ff [2];
   logic [1:0]                        phase_in [2];
   logic [1:0]                        dir_ff, dir_in;

   logic                              accept;
   logic [kmsd_pkg::ROW_W-1:0]        row_cur;
   logic [kmsd_pkg::ROW_W-1:0]        row_after;
   logic [kmsd_pkg::PINS_W-1:0]       raw_pins [2];
   logic [kmsd_pkg::PINS_W-1:0]       cur_pins;
   logic [2:0]                        col;
   logic                              mat_on;
   logic [1:0]                        rbits;
   logic [1:0]                        ph;
   logic [1:0]                        phase_new;
   logic [1:0]                        dir_new;
   logic                              on;

   assign in_ready = (state_ff == ST_IDLE);
   assign accept   = in_valid && in_ready;
   assign raw_pins[0] = left_pins;
   assign raw_pins[1] = right_pins;

   always_comb begin
      row_cur   = (int'(row_ff) >= ROWS) ? '0 : row_ff;
      row_after = (int'(row_cur) + 1 >= ROWS) ? '0 : kmsd_pkg::ROW_W'(int'(row_cur) + 1);
   end

   always_comb begin
      cur_pins = pins_ff[side_ff];
      col      = 3'(pos_ff);
      mat_on   = (int'(pos_ff) < kmsd_pkg::WIRED_COLS) &&
                 cur_pins[kmsd_pkg::col_pin(side_ff, col)];
      rbits    = {cur_pins[kmsd_pkg::enc_pin(side_ff, 1'b1)],
                  cur_pins[kmsd_pkg::enc_pin(side_ff, 1'b0)]};
      ph        = phase_ff[side_ff];
      phase_new = ph;
      dir_new   = kmsd_pkg::PHASE_NONE;
      if (ph == kmsd_pkg::PHASE_NONE) begin
         phase_new = rbits;
      end else if (rbits == kmsd_pkg::PHASE_NONE) begin
         phase_new = kmsd_pkg::PHASE_NONE;
      end else if ((ph | rbits) == kmsd_pkg::BOTH_PHASES) begin
         dir_new = ph;
      end
      if (pos_ff < POS_ROT0) begin
         on       = mat_on;
         step_key = KEY_W'(int'(side_ff) * MAT_SIDE + int'(curr_ff) * COLS + int'(pos_ff));
      end else begin
         on       = (pos_ff == POS_ROT0) ? (dir_new == kmsd_pkg::PHASE_B)
                                         : (dir_ff == kmsd_pkg::PHASE_A);
         step_key = KEY_W'(MAT_KEYS + int'(side_ff) * 2 + int'(pos_ff) - COLS);
      end
   end

   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      pos_in   = pos_ff;
      curr_in  = curr_ff;
      row_in   = row_ff;
      fault_in = fault_ff;
      time_in  = time_ff;
      dir_in   = dir_ff;
      for (int s = 0; s < 2; s++) begin
         pins_in[s]  = pins_ff[s];
         phase_in[s] = phase_ff[s];
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               side_in  = 1'b0;
               pos_in   = '0;
               curr_in  = row_cur;
               row_in   = row_after;
               time_in  = time_stamp;
               for (int s = 0; s < 2; s++) begin
                  fault_in[s] = 1'b0;
                  pins_in[s]  = '0;
                  if (side_enable[s] && side_ready[s]) begin
                     if (raw_pins[s] == kmsd_pkg::ALL_ONES) begin
                        fault_in[s] = 1'b1;
                     end else begin
                        pins_in[s] = raw_pins[s];
                     end
                  end
               end
            end
         end
         ST_RUN: begin
            if (ctl.advance) begin
               if (pos_ff == POS_ROT0) begin
                  phase_in[side_ff] = phase_new;
                  dir_in            = dir_new;
               end
               if (pos_ff == POS_ROT1) begin
                  pos_in = '0;
                  if (side_ff == SIDE_LAST) begin
                     state_in = ST_DONE;
                  end else begin
                     side_in = 1'b1;
                  end
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (ctl.done_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         side_ff  <= 1'b0;
         pos_ff   <= '0;
         row_ff   <= '0;
         dir_ff   <= kmsd_pkg::PHASE_NONE;
         for (int s = 0; s < 2; s++) begin
            phase_ff[s] <= kmsd_pkg::PHASE_NONE;
         end
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
         pos_ff   <= pos_in;
         row_ff   <= row_in;
         dir_ff   <= dir_in;
         for (int s = 0; s < 2; s++) begin
            phase_ff[s] <= phase_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      curr_ff  <= curr_in;
      fault_ff <= fault_in;
      time_ff  <= time_in;
      for (int s = 0; s < 2; s++) begin
         pins_ff[s] <= pins_in[s];
      end
   end

   always_comb begin
      sts.step_valid = (state_ff == ST_RUN);
      sts.sample_on  = on;
      sts.done_pend  = (state_ff == ST_DONE);
      sts.drive_row  = row_ff;
      sts.fault      = fault_ff;
      sts.time_stamp = time_ff;
   end

endmodule

[hdl/key_matrix_scan_debounce.sv]
// key matrix row scanner with two-sample debounce, top level
//
//  channel  dir  handshake               payload
//  req      in   req_tvalid/req_tready   tdata: left_pins, right_pins, time_stamp;
//                                        tuser: side_ready
//  rsp      out  rsp_tvalid/rsp_tready   tdata: key_index, event_time, drive_row, read_fault;
//                                        tuser: kind; tlast: last
//  csr      in   csr_valid/csr_ready     csr_wdata: side_enable
//
//  a scan reads one key history entry a cycle on the memory port unless stalled, evaluates
//  it the next cycle and writes it back once not stalled, then sends the scan done word
//  a stalled rsp word holds the key pipeline whenever another key edge is ready to leave
//  reset clears the history valid bits, encoder phases, scan row and side_enable to 3
//  the next scan is taken once the scan done word sits in the output register
module key_matrix_scan_debounce #(
   parameter int ROWS  = kmsd_pkg::ROWS_DEF,
   parameter int COLS  = kmsd_pkg::COLS_DEF,
   parameter int SIDES = kmsd_pkg::SIDES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // left_pins, right_pins, time_stamp
   input  logic [1:0]  req_tuser,   // side_ready
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // key_index, event_time, drive_row, read_fault, zero fill
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_wdata
);

   localparam int NUM_KEYS = SIDES * ROWS * COLS + 2 * SIDES;
   localparam int KEY_W    = $clog2(NUM_KEYS);

   logic [1:0]                        side_enable_ff;
   kmsd_pkg::seq_ctl_type             ctl;
   kmsd_pkg::seq_sts_type             sts;
   logic [KEY_W-1:0]                  step_key;

   logic                              ev_valid_ff, ev_valid_in;
   logic [KEY_W-1:0]                  ev_key_ff, ev_key_in;
   logic                              ev_on_ff, ev_on_in;

   logic [1:0]                        hist_rd;
   logic [1:0]                        hist_new;
   logic                              pressed;
   logic                              hist_flip;
   logic                              slot_free;
   logic                              stall;
   logic                              advance;
   logic                              ev_load;
   logic                              done_load;
   logic                              wr_en;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [kmsd_pkg::KIND_W-1:0]       rsp_kind_ff, rsp_kind_in;
   logic [kmsd_pkg::KEY_IDX_W-1:0]    rsp_key_ff, rsp_key_in;
   logic [kmsd_pkg::TIME_W-1:0]       rsp_time_ff, rsp_time_in;
   logic [kmsd_pkg::ROW_W-1:0]        rsp_row_ff, rsp_row_in;
   logic [1:0]                        rsp_fault_ff, rsp_fault_in;
   logic                              rsp_last_ff, rsp_last_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_enable_ff <= 2'b11;
      end else if (csr_valid && csr_ready) begin
         side_enable_ff <= csr_wdata;
      end
   end

   kmsd_scan_seq #(
      .ROWS  (ROWS),
      .COLS  (COLS),
      .SIDES (SIDES),
      .KEY_W (KEY_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .side_enable (side_enable_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .left_pins   (req_tdata[15:0]),
      .right_pins  (req_tdata[31:16]),
      .side_ready  (req_tuser),
      .time_stamp  (req_tdata[63:32]),
      .ctl         (ctl),
      .sts         (sts),
      .step_key    (step_key)
   );

   kmsd_hist_ram #(
      .DEPTH  (NUM_KEYS),
      .ADDR_W (KEY_W)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (advance),
      .rd_addr (step_key),
      .rd_data (hist_rd),
      .wr_en   (wr_en),
      .wr_addr (ev_key_ff),
      .wr_data (hist_new)
   );

   always_comb begin
      pressed   = hist_rd[0] && ev_on_ff;
      hist_new  = {pressed, ev_on_ff};
      hist_flip = (hist_rd[1] != pressed);
      slot_free = !rsp_valid_ff || rsp_tready;
      stall     = ev_valid_ff && hist_flip && !slot_free;
      advance   = sts.step_valid && !stall;
      wr_en     = ev_valid_ff && !stall;
      ev_load   = ev_valid_ff && hist_flip && slot_free;
      done_load = sts.done_pend && !ev_valid_ff && slot_free;
      ctl.advance   = advance;
      ctl.done_take = done_load;
   end

   always_comb begin
      ev_valid_in = ev_valid_ff;
      ev_key_in   = ev_key_ff;
      ev_on_in    = ev_on_ff;
      if (!stall) begin
         ev_valid_in = sts.step_valid;
         ev_key_in   = step_key;
         ev_on_in    = sts.sample_on;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_last_in  = rsp_last_ff;
      if (ev_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = pressed ? kmsd_pkg::KIND_PRESS : kmsd_pkg::KIND_RELEASE;
         rsp_key_in   = kmsd_pkg::KEY_IDX_W'(ev_key_ff);
         rsp_time_in  = sts.time_stamp;
         rsp_row_in   = '0;
         rsp_fault_in = 2'b00;
         rsp_last_in  = 1'b0;
      end else if (done_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = kmsd_pkg::KIND_DONE;
         rsp_key_in   = '0;
         rsp_time_in  = sts.time_stamp;
         rsp_row_in   = sts.drive_row;
         rsp_fault_in = sts.fault;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_key_ff    <= ev_key_in;
      ev_on_ff     <= ev_on_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_fault_ff <= rsp_fault_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000, rsp_fault_ff, rsp_row_ff, rsp_time_ff, rsp_key_ff};

`ifndef SYNTH
   a_last_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == kmsd_pkg::KIND_DONE)
      else $error("last word is not a scan done word");

   a_accept_empty: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !ev_valid_ff && !sts.done_pend)
      else $error("scan taken while keys still in flight");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      advance && wr_en |-> step_key != ev_key_ff)
      else $error("history read and write hit the same entry");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> ev_valid_ff && $stable(ev_key_ff) && $stable(ev_on_ff))
      else $error("evaluated key lost during output stall");

   a_done_then_idle: assert property (@(posedge clock) disable iff (reset)
      done_load |=> req_tready)
      else $error("sequencer not idle after scan done");
`endif

endmodule

[test/testbench.sv]
// self-checking testbench for the key matrix row scanner with debounce
`timescale 1ns / 1ps

module testbench;

   localparam int ROWS        = kmsd_pkg::ROWS_DEF;
   localparam int COLS        = kmsd_pkg::COLS_DEF;
   localparam int SIDES       = kmsd_pkg::SIDES_DEF;
   localparam int MATRIX_KEYS = SIDES * ROWS * COLS;
   localparam int KEY_COUNT   = MATRIX_KEYS + SIDES * 2;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 30;

   // column pin per side and column, nibble (side*8+col)
   localparam logic [63:0] COL_PINS = 64'hCBA9_8763_4567_89AD;
   // encoder phase pin per side and phase, nibble (side*2+phase)
   localparam logic [15:0] ENC_PINS = 16'hED23;

   typedef struct {
      logic [kmsd_pkg::KIND_W-1:0]    kind;
      logic [kmsd_pkg::KEY_IDX_W-1:0] key;
      logic [kmsd_pkg::TIME_W-1:0]    stamp;
      logic [kmsd_pkg::ROW_W-1:0]     row;
      logic [1:0]                     fault;
      logic                           last;
   } scan_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // left_pins, right_pins, time_stamp
   logic [1:0]  req_tuser = '0;   // side_ready
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;       // key_index, event_time, drive_row, read_fault, zero fill
   logic [1:0]  rsp_tuser;       // kind
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_wdata = '0;

   scan_word_type pending_words [$];
   logic [1:0]  key_hist [0:KEY_COUNT-1];
   logic [1:0]  enc_phase [0:1];
   logic [2:0]  row_now;
   logic [1:0]  side_en_now;
   logic [15:0] held_pins [0:1][0:ROWS-1];
   int          errors = 0;
   int          hold_cycles = 0;
   bit          gaps_on = 1'b0;

   key_matrix_scan_debounce DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic void clear_scan_state();
      for (int k = 0; k < KEY_COUNT; k++) key_hist[k] = 2'b00;
      enc_phase[0] = kmsd_pkg::PHASE_NONE;
      enc_phase[1] = kmsd_pkg::PHASE_NONE;
      row_now = '0;
      side_en_now = 2'd3;
   endfunction

   function automatic void debounce_key(input int key, input logic on, input logic [31:0] stamp);
      logic [1:0] old;
      logic [1:0] nw;
      scan_word_type w;
      old = key_hist[key];
      nw = {old[0] & on, on};
      key_hist[key] = nw;
      if (old[1] != nw[1]) begin
         w.kind  = nw[1] ? kmsd_pkg::KIND_PRESS : kmsd_pkg::KIND_RELEASE;
         w.key   = 7'(key);
         w.stamp = stamp;
         w.row   = '0;
         w.fault = '0;
         w.last  = 1'b0;
         pending_words.insert(pending_words.size(), w);
      end
   endfunction

   function automatic void predict_scan_words(input logic [15:0] left, input logic [15:0] right,
                                              input logic [1:0] ready, input logic [31:0] stamp);
      logic [15:0] pins [0:1];
      logic [1:0]  fault;
      logic [2:0]  row;
      logic [2:0]  nxt;
      logic [1:0]  rbits;
      logic [1:0]  dir;
      scan_word_type w;
      row = (row_now >= ROWS) ? 3'd0 : row_now;
      nxt = (row == ROWS - 1) ? 3'd0 : row + 3'd1;
      row_now = nxt;
      pins[0] = left;
      pins[1] = right;
      fault = '0;
      for (int s = 0; s < 2; s++) begin
         if (!side_en_now[s] || !ready[s]) begin
            pins[s] = '0;
         end else if (pins[s] == kmsd_pkg::ALL_ONES) begin
            fault[s] = 1'b1;
            pins[s] = '0;
         end
      end
      for (int s = 0; s < SIDES; s++) begin
         for (int c = 0; c < COLS; c++) begin
            debounce_key(s * ROWS * COLS + row * COLS + c,
                         (c < kmsd_pkg::WIRED_COLS) ? pins[s][COL_PINS[(s * 8 + c) * 4 +: 4]]
                                                    : 1'b0,
                         stamp);
         end
         rbits = {pins[s][ENC_PINS[(s * 2 + 1) * 4 +: 4]], pins[s][ENC_PINS[(s * 2) * 4 +: 4]]};
         dir = kmsd_pkg::PHASE_NONE;
         if (enc_phase[s] == kmsd_pkg::PHASE_NONE) begin
            enc_phase[s] = rbits;
         end else if (rbits == kmsd_pkg::PHASE_NONE) begin
            enc_phase[s] = kmsd_pkg::PHASE_NONE;
         end else if ((enc_phase[s] | rbits) == kmsd_pkg::BOTH_PHASES) begin
            dir = enc_phase[s];
         end
         debounce_key(MATRIX_KEYS + s * 2, dir == kmsd_pkg::PHASE_B, stamp);
         debounce_key(MATRIX_KEYS + s * 2 + 1, dir == kmsd_pkg::PHASE_A, stamp);
      end
      w.kind  = kmsd_pkg::KIND_DONE;
      w.key   = '0;
      w.stamp = stamp;
      w.row   = nxt;
      w.fault = fault;
      w.last  = 1'b1;
      pending_words.insert(pending_words.size(), w);
   endfunction

   function automatic void field_check(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic check_rsp_word();
      scan_word_type want;
      if (pending_words.size() == 0) begin
         $display("%0t: unexpected word, expected none, actual kind %0h key %0h", $time,
                  rsp_tuser, rsp_tdata[6:0]);
         errors++;
      end else begin
         want = pending_words.pop_front();
         field_check("kind", 32'(want.kind), 32'(rsp_tuser));
         field_check("key_index", 32'(want.key), 32'(rsp_tdata[6:0]));
         field_check("event_time", want.stamp, rsp_tdata[38:7]);
         field_check("drive_row", 32'(want.row), 32'(rsp_tdata[41:39]));
         field_check("read_fault", 32'(want.fault), 32'(rsp_tdata[43:42]));
         field_check("last", 32'(want.last), 32'(rsp_tlast));
      end
   endtask

   task automatic send_scan(input logic [15:0] left, input logic [15:0] right,
                            input logic [1:0] ready, input logic [31:0] stamp);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {stamp, right, left};
      req_tuser  <= ready;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_scan_words(left, right, ready, stamp);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_side_enable(input logic [1:0] value);
      wait_drain();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      side_en_now = value;
   endtask

   task automatic send_random_scan();
      logic [15:0] pins [0:1];
      logic [1:0]  ready;
      int          pick;
      pick = $urandom_range(0, 99);
      for (int s = 0; s < 2; s++) begin
         if ($urandom_range(0, 2) == 0)
            held_pins[s][row_now] ^= 16'h1 << $urandom_range(0, 15);
         if (pick < 70)
            pins[s] = held_pins[s][row_now];
         else if (pick < 85)
            pins[s] = 16'($urandom);
         else if (pick < 93)
            pins[s] = $urandom_range(0, 1) ? kmsd_pkg::ALL_ONES : held_pins[s][row_now];
         else
            pins[s] = '0;
      end
      ready = ($urandom_range(0, 99) < 85) ? 2'd3 : 2'($urandom_range(0, 3));
      send_scan(pins[0], pins[1], ready, $urandom);
   endtask

   task automatic test_directed_edges();
      gaps_on = 1'b1;
      send_scan(16'h0000, 16'h0000, 2'd3, 32'h0000_0000);
      send_scan(kmsd_pkg::ALL_ONES, kmsd_pkg::ALL_ONES, 2'd3, 32'hffff_ffff);
      send_scan(kmsd_pkg::ALL_ONES, 16'h0000, 2'd1, 32'h0000_0001);
      send_scan(kmsd_pkg::ALL_ONES, kmsd_pkg::ALL_ONES, 2'd2, 32'h0000_0002);
      // every matrix key on twice per row, then off
      repeat (10) send_scan(16'hfffe, 16'hfffe, 2'd3, $urandom);
      repeat (5) send_scan(16'h0000, 16'h0000, 2'd3, $urandom);
      // left encoder turns one way, right one reads both phases at once
      send_scan(16'h0008, 16'h6000, 2'd3, 32'h8000_0000);
      send_scan(16'h000c, 16'h2000, 2'd3, 32'h7fff_ffff);
      send_scan(16'h000c, 16'h2000, 2'd3, 32'h1234_5678);
      send_scan(16'h0000, 16'h0000, 2'd3, 32'h0000_0010);
      send_scan(16'h5555, 16'haaaa, 2'd0, 32'h0000_0020);
      send_scan(16'haaaa, 16'h5555, 2'd3, 32'h0000_0040);
      wait_drain();
   endtask

   task automatic test_side_enable();
      logic [1:0] settings [0:3];
      settings[0] = 2'd0;
      settings[1] = 2'd1;
      settings[2] = 2'd2;
      settings[3] = 2'd3;
      gaps_on = 1'b1;
      for (int i = 0; i < 4; i++) begin
         write_side_enable(settings[i]);
         repeat (20) send_random_scan();
      end
      wait_drain();
   endtask

   task automatic test_receiver_hold();
      gaps_on = 1'b0;
      hold_cycles = HOLD_CYCLES;
      repeat (30) send_random_scan();
      wait_drain();
   endtask

   task automatic test_random_traffic();
      gaps_on = 1'b1;
      for (int i = 0; i < 165; i++) begin
         if (i == 80)
            wait_drain();
         if (i == 135)
            gaps_on = 1'b0;
         send_random_scan();
      end
      wait_drain();
   endtask

   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            check_rsp_word();
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      for (int s = 0; s < 2; s++)
         for (int r = 0; r < ROWS; r++)
            held_pins[s][r] = 16'($urandom);
      clear_scan_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_side_enable();
      test_receiver_hold();
      test_random_traffic();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_words.size() != 0) begin
         $display("%0t: %0d words expected, actual none", $time, pending_words.size());
         errors++;
      end
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
